// ===== rtl/core/pac_pkg.sv =====
// pac_pkg: shared widths, register indexes and divider request/response types
// for the knob average and calibration block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pac_pkg;

  localparam int SAMPLE_W = 12;
  localparam int PCT_W    = 7;
  localparam int THR_W    = 7;
  localparam int LAST_W   = 8;
  localparam int CFG_IDX_W = 2;

  // shared divider: dividend covers 100*4095+4095 and 64*4095
  localparam int DIV_N_W  = 19;
  localparam int DIV_D_W  = 13;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd3;

  localparam logic [SAMPLE_W-1:0] CAL_LOW_RST    = 12'd559;
  localparam logic [SAMPLE_W-1:0] CAL_MIDDLE_RST = 12'd945;
  localparam logic [SAMPLE_W-1:0] CAL_HIGH_RST   = 12'd3071;
  localparam logic [THR_W-1:0]    THRESHOLD_RST  = 7'd2;
  localparam logic [LAST_W-1:0]   LAST_RST       = 8'hFF;

  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/pac_ring.sv =====
// pac_ring: sample ring storage, one write port and one registered read port.
// Uses pac_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module pac_ring #(
  parameter int AVG_DEPTH = 8,
  parameter int IDX_W     = 3
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [IDX_W-1:0]              waddr,
  input  wire logic [pac_pkg::SAMPLE_W-1:0]  wdata,
  input  wire logic                          re,
  input  wire logic [IDX_W-1:0]              raddr,
  output      logic [pac_pkg::SAMPLE_W-1:0]  rdata
);
  import pac_pkg::*;

  logic [SAMPLE_W-1:0] mem [AVG_DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/pac_div.sv =====
// pac_div: restoring divider, one quotient bit per cycle, shared by the mean
// and the calibration segment. Uses pac_pkg request/response types.
`timescale 1ns / 1ps
`default_nettype none

module pac_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pac_pkg::div_req_t req,
  output      pac_pkg::div_rsp_t rsp
);
  import pac_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   dsr_r;

  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     rem_diff;
  logic                 ge;
  logic [DIV_D_W-1:0]   rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_N_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = ge ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/pot_average_calibrate.sv =====
// pot_average_calibrate: knob position in percent from a moving average of
// converter samples. Depends on pac_pkg, pac_ring and pac_div.
//
// Input channel: in_valid / in_stall carry one 12-bit sample per beat. The
// sample goes into a ring of AVG_DEPTH slots; the mean of the slots written so
// far (all of them once the ring has wrapped) is mapped through the three-point
// calibration in cfg registers 0..2 to 0..100 percent, rounded half up.
// Output channel: out_valid / out_stall carry percent, changed and raw_average,
// one beat per input beat. changed is set when percent moved by more than
// change_threshold (register 3) from the last percent reported as changed,
// which starts at 255, so the first beat always reports a change.
// Timing: one item at a time. The n ring slots are summed, then the shared
// bit-serial divider computes the mean and, unless the mean lies at or outside
// the calibration span, the segment. in_stall is high while an item is in
// flight. A finished result sits in the output register while the next sample
// is already accepted; if the receiver still stalls when that next result is
// done, the block holds it and waits.
// Reset (rst_n low, synchronous) empties the ring, loads the calibration
// defaults and drops out_valid. Configuration is written with cfg_we.
`timescale 1ns / 1ps
`default_nettype none

module pot_average_calibrate #(
  parameter int AVG_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [pac_pkg::SAMPLE_W-1:0]  in_sample,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [pac_pkg::PCT_W-1:0]     out_percent,
  output      logic                          out_changed,
  output      logic [pac_pkg::SAMPLE_W-1:0]  out_raw_average,
  input  wire logic                          cfg_we,
  input  wire logic [pac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pac_pkg::SAMPLE_W-1:0]  cfg_wdata
);
  import pac_pkg::*;

  localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W = $clog2(AVG_DEPTH * 4095 + 1);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SUM       = 7'b0000010,
    ST_MEAN_GO   = 7'b0000100,
    ST_MEAN_WAIT = 7'b0001000,
    ST_CAL       = 7'b0010000,
    ST_SEG_WAIT  = 7'b0100000,
    ST_REPORT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [SAMPLE_W-1:0] cal_low_r, cal_mid_r, cal_high_r;
  logic [THR_W-1:0]    thr_r;

  // ring bookkeeping
  logic [IDX_W-1:0]    wi_r;
  logic                full_r;
  logic [CNT_W-1:0]    wi_inc;
  logic [CNT_W-1:0]    n_r;

  // summing
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                rd_pend_r;
  logic [SUM_W-1:0]    sum_r;
  logic                ring_re;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic                sum_done;

  // calibration
  logic [SAMPLE_W-1:0] mean_r;
  logic [PCT_W-1:0]    pct_r;
  logic [PCT_W-1:0]    seg_base_r;
  logic                below, above, lower;
  logic [SAMPLE_W-1:0] seg_num, seg_d;
  logic [DIV_N_W-1:0]  seg_dividend;
  logic [DIV_N_W:0]    seg_pct_wide;
  logic [PCT_W-1:0]    seg_pct;

  // report
  logic [LAST_W-1:0]   last_r;
  logic [LAST_W-1:0]   diff;
  logic                chg;
  logic                out_free;
  logic                accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign wi_inc   = CNT_W'(wi_r) + 1'b1;

  pac_ring #(
    .AVG_DEPTH (AVG_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wi_r),
    .wdata (in_sample),
    .re    (ring_re),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ring_rdata)
  );

  pac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= CAL_LOW_RST;
      cal_mid_r  <= CAL_MIDDLE_RST;
      cal_high_r <= CAL_HIGH_RST;
      thr_r      <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_LOW:    cal_low_r  <= cfg_wdata;
        REG_CAL_MIDDLE: cal_mid_r  <= cfg_wdata;
        REG_CAL_HIGH:   cal_high_r <= cfg_wdata;
        REG_THRESHOLD:  thr_r      <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ring read sequencing; data comes back in the cycle after the address
  assign ring_re  = (state_r == ST_SUM) && (rd_cnt_r != n_r);
  assign sum_done = (rd_cnt_r == n_r) && !rd_pend_r;

  // segment selection; low point first, then high, then middle
  always_comb begin
    below = mean_r <= cal_low_r;
    above = mean_r >= cal_high_r;
    lower = mean_r <= cal_mid_r;
    seg_num = lower ? (mean_r - cal_low_r) : (mean_r - cal_mid_r);
    seg_d   = lower ? (cal_mid_r - cal_low_r) : (cal_high_r - cal_mid_r);
    seg_dividend = {7'd0, seg_num} * DIV_N_W'(PCT_FULL) + DIV_N_W'(seg_d);
  end

  // divider requests: mean first, then the segment
  always_comb begin
    div_req = '0;
    if (state_r == ST_MEAN_GO) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'(sum_r);
      div_req.divisor  = DIV_D_W'(n_r);
    end else if (state_r == ST_CAL) begin
      div_req.start    = !below && !above;
      div_req.dividend = seg_dividend;
      div_req.divisor  = {seg_d, 1'b0};
    end
  end

  // segment result, clamped to 100
  always_comb begin
    seg_pct_wide = {1'b0, div_rsp.quotient} + (DIV_N_W + 1)'(seg_base_r);
    seg_pct = (seg_pct_wide > (DIV_N_W + 1)'(PCT_FULL)) ? PCT_FULL
                                                       : seg_pct_wide[PCT_W-1:0];
  end

  always_comb begin
    diff = ({1'b0, pct_r} > last_r) ? ({1'b0, pct_r} - last_r)
                                     : (last_r - {1'b0, pct_r});
    chg  = diff > {1'b0, thr_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (accept) state_nxt = ST_SUM;
      ST_SUM:       if (sum_done) state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_rsp.done) state_nxt = ST_CAL;
      ST_CAL:       state_nxt = (below || above) ? ST_REPORT : ST_SEG_WAIT;
      ST_SEG_WAIT:  if (div_rsp.done) state_nxt = ST_REPORT;
      ST_REPORT:    if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wi_r      <= '0;
      full_r    <= 1'b0;
      last_r    <= LAST_RST;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
      rd_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= ring_re;
      if (accept) begin
        rd_cnt_r <= '0;
        if (wi_inc == CNT_W'(AVG_DEPTH)) begin
          wi_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wi_r <= wi_inc[IDX_W-1:0];
        end
      end else if (ring_re) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (state_r == ST_REPORT && out_free) begin
        out_valid <= 1'b1;
        if (chg) last_r <= {1'b0, pct_r};
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= '0;
      n_r   <= (full_r || wi_inc == CNT_W'(AVG_DEPTH)) ? CNT_W'(AVG_DEPTH) : wi_inc;
    end else if (rd_pend_r) begin
      sum_r <= sum_r + SUM_W'(ring_rdata);
    end
    if (state_r == ST_MEAN_WAIT && div_rsp.done) begin
      mean_r <= div_rsp.quotient[SAMPLE_W-1:0];
    end
    if (state_r == ST_CAL) begin
      seg_base_r <= lower ? PCT_ZERO : PCT_HALF;
      if (below) begin
        pct_r <= PCT_ZERO;
      end else if (above) begin
        pct_r <= PCT_FULL;
      end
    end
    if (state_r == ST_SEG_WAIT && div_rsp.done) begin
      pct_r <= seg_pct;
    end
    if (state_r == ST_REPORT && out_free) begin
      out_percent     <= pct_r;
      out_changed     <= chg;
      out_raw_average <= mean_r;
    end
  end

endmodule

`default_nettype wire
